// ----- src/ftc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ftc_pkg;

  // Table geometry and field widths.
  localparam int FRAMES        = 64;
  localparam int FRAME_BITS    = $clog2(FRAMES);
  localparam int CFG_BITS      = 7;
  localparam int OP_BITS       = 3;
  localparam int KEY_BITS_DEF  = 16;
  localparam int PAGE_BITS_DEF = 16;
  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(FRAMES);

  // Operation codes carried by the request channel.
  typedef enum logic [OP_BITS-1:0] {
    OP_LOOKUP    = 3'd0,
    OP_FIND_FREE = 3'd1,
    OP_ASSIGN    = 3'd2,
    OP_RELEASE   = 3'd3,
    OP_VICTIM    = 3'd4,
    OP_TOUCH     = 3'd5
  } op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LK_RD,
    ST_LK_CMP,
    ST_FF,
    ST_VS,
    ST_RD,
    ST_RPT,
    ST_ZERO
  } state_t;

  // Frame pointer update selection.
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_IDX,
    PTR_HAND,
    PTR_STEP
  } ptr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    ptr_sel_t ptr_sel;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     pass_set;
    logic     vs_scan;
    logic     mem_rd;
    logic     hand_adv;
    logic     report;
    logic     report_zero;
    logic     commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               idx_ok;
    logic               occ_ptr;
    logic               lk_match;
    logic               vs_hit;
    logic               last;
    logic               pass;
    logic               out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- src/ftc_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ftc_req_if
  import ftc_pkg::*;
#(
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    op;
  logic [KEY_BITS-1:0]   owner_key;
  logic [PAGE_BITS-1:0]  page_number;
  logic [FRAME_BITS-1:0] frame_index;
  logic                  write_flag;

  modport source (
    output valid, op, owner_key, page_number, frame_index, write_flag,
    input  ready
  );

  modport sink (
    input  valid, op, owner_key, page_number, frame_index, write_flag,
    output ready
  );

endinterface

`default_nettype wire

// ----- src/ftc_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ftc_rsp_if
  import ftc_pkg::*;
#(
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [FRAME_BITS-1:0] frame;
  logic                  frame_dirty;
  logic [KEY_BITS-1:0]   frame_owner;
  logic [PAGE_BITS-1:0]  frame_page;

  modport source (
    output valid, found, frame, frame_dirty, frame_owner, frame_page,
    input  ready
  );

  modport sink (
    input  valid, found, frame, frame_dirty, frame_owner, frame_page,
    output ready
  );

endinterface

`default_nettype wire

// ----- src/frame_table_clock_replacement.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Contents
// req      in         op, owner_key, page_number, frame_index, write_flag
// rsp      out        found, frame, frame_dirty, frame_owner, frame_page
// cfg      in         frames_in_use, written when cfg_wr_en is high
//
// One request is worked at a time. With n frames in use, assign, release and
// touch act on the indexed frame; find free and lookup scan up to n frames,
// victim up to two passes of n. Find free and victim step one frame per cycle;
// lookup reads the owner and page memory, registered, before each compare.
// Synchronous reset clears the frame status bits and the hand at once; there
// is no clearing pass. A stalled result holds the block in its last state.

module frame_table_clock_replacement
  import ftc_pkg::*;
#(
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_BITS-1:0] cfg_wr_data,
  ftc_req_if.sink             req,
  ftc_rsp_if.source           rsp
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  // Sequencing of each operation.
  ftc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;

  // Frame table storage, scan pointer and result register.
  ftc_dp #(
    .KEY_BITS  (KEY_BITS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_op           (req.op),
    .in_owner_key    (req.owner_key),
    .in_page_number  (req.page_number),
    .in_frame_index  (req.frame_index),
    .in_write_flag   (req.write_flag),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .out_found       (rsp.found),
    .out_frame       (rsp.frame),
    .out_frame_dirty (rsp.frame_dirty),
    .out_frame_owner (rsp.frame_owner),
    .out_frame_page  (rsp.frame_page)
  );

endmodule

`default_nettype wire

// ----- src/ftc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ftc_ctrl
  import ftc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.op)
          OP_LOOKUP:    state_next = ST_LK_RD;
          OP_FIND_FREE: state_next = ST_FF;
          OP_VICTIM:    state_next = ST_VS;
          OP_ASSIGN, OP_RELEASE, OP_TOUCH: begin
            state_next = sts.idx_ok ? ST_RD : ST_ZERO;
          end
          default:      state_next = ST_ZERO;
        endcase
      end
      ST_LK_RD: begin
        state_next = ST_LK_CMP;
      end
      ST_LK_CMP: begin
        if (sts.lk_match) begin
          state_next = ST_RPT;
        end else if (sts.last) begin
          state_next = ST_ZERO;
        end else begin
          state_next = ST_LK_RD;
        end
      end
      ST_FF: begin
        if (!sts.occ_ptr) begin
          state_next = ST_RD;
        end else if (sts.last) begin
          state_next = ST_ZERO;
        end
      end
      ST_VS: begin
        // After the second full pass the pointer has wrapped back to the hand.
        if (sts.vs_hit || (sts.last && sts.pass)) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_RPT;
      end
      ST_RPT, ST_ZERO: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd         = '0;
    cmd.ptr_sel = PTR_HOLD;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        // No request is taken while reset is held.
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_DISPATCH: begin
        cmd.cnt_clr = 1'b1;
        case (sts.op)
          OP_LOOKUP, OP_FIND_FREE:        cmd.ptr_sel = PTR_ZERO;
          OP_VICTIM:                      cmd.ptr_sel = PTR_HAND;
          OP_ASSIGN, OP_RELEASE, OP_TOUCH: cmd.ptr_sel = PTR_IDX;
          default:                        cmd.ptr_sel = PTR_HOLD;
        endcase
      end
      ST_LK_RD: begin
        cmd.mem_rd = 1'b1;
      end
      ST_LK_CMP: begin
        if (!sts.lk_match && !sts.last) begin
          cmd.ptr_sel = PTR_STEP;
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_FF: begin
        if (sts.occ_ptr && !sts.last) begin
          cmd.ptr_sel = PTR_STEP;
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_VS: begin
        cmd.vs_scan = 1'b1;
        if (!sts.vs_hit) begin
          cmd.ptr_sel = PTR_STEP;
          if (sts.last) begin
            cmd.cnt_clr  = 1'b1;
            cmd.pass_set = 1'b1;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_RD: begin
        cmd.mem_rd   = 1'b1;
        cmd.hand_adv = (sts.op == OP_VICTIM);
      end
      ST_RPT: begin
        cmd.report = sts.out_free;
        cmd.commit = sts.out_free;
      end
      ST_ZERO: begin
        cmd.report_zero = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/ftc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ftc_dp
  import ftc_pkg::*;
#(
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_BITS-1:0]   cfg_wr_data,
  input  logic [OP_BITS-1:0]    in_op,
  input  logic [KEY_BITS-1:0]   in_owner_key,
  input  logic [PAGE_BITS-1:0]  in_page_number,
  input  logic [FRAME_BITS-1:0] in_frame_index,
  input  logic                  in_write_flag,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [FRAME_BITS-1:0] out_frame,
  output logic                  out_frame_dirty,
  output logic [KEY_BITS-1:0]   out_frame_owner,
  output logic [PAGE_BITS-1:0]  out_frame_page
);

  logic [CFG_BITS-1:0]   frames_in_use;
  logic [OP_BITS-1:0]    op;
  logic [KEY_BITS-1:0]   key;
  logic [PAGE_BITS-1:0]  page;
  logic [FRAME_BITS-1:0] idx;
  logic                  wr;
  logic [FRAME_BITS-1:0] last_frame;
  logic [FRAME_BITS-1:0] last_frame_next;
  logic [CFG_BITS-1:0]   fiu_m1;
  logic [FRAME_BITS-1:0] ptr;
  logic [FRAME_BITS-1:0] ptr_step;
  logic [FRAME_BITS-1:0] hand_start;
  logic [FRAME_BITS-1:0] cnt;
  logic                  pass;
  logic [FRAME_BITS-1:0] hand;
  logic [FRAMES-1:0]     occ;
  logic [FRAMES-1:0]     used;
  logic [FRAMES-1:0]     dirty;
  logic [KEY_BITS-1:0]   owner_mem [FRAMES];
  logic [PAGE_BITS-1:0]  page_mem [FRAMES];
  logic [KEY_BITS-1:0]   rd_owner;
  logic [PAGE_BITS-1:0]  rd_page;
  logic                  vs_hit;
  logic                  out_free;

  // Frame count register; write it only while idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  // Highest usable frame: a count of zero acts as one, a large count saturates.
  assign fiu_m1 = frames_in_use - 1'b1;
  always_comb begin
    if (frames_in_use == '0) begin
      last_frame_next = '0;
    end else if (frames_in_use > CFG_BITS'(FRAMES)) begin
      last_frame_next = FRAME_BITS'(FRAMES - 1);
    end else begin
      last_frame_next = fiu_m1[FRAME_BITS-1:0];
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= in_op;
      key        <= in_owner_key;
      page       <= in_page_number;
      idx        <= in_frame_index;
      wr         <= in_write_flag;
      last_frame <= last_frame_next;
    end
  end

  // Scan pointer, wrapping at the frame count.
  assign ptr_step   = (ptr == last_frame) ? '0 : ptr + 1'b1;
  assign hand_start = (hand <= last_frame) ? hand : '0;

  always_ff @(posedge clk) begin
    case (cmd.ptr_sel)
      PTR_ZERO: ptr <= '0;
      PTR_IDX:  ptr <= idx;
      PTR_HAND: ptr <= hand_start;
      PTR_STEP: ptr <= ptr_step;
      default:  ptr <= ptr;
    endcase
  end

  // Step counter and pass flag for the scans.
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.load) begin
      pass <= 1'b0;
    end else if (cmd.pass_set) begin
      pass <= 1'b1;
    end
  end

  // Clock hand moves to the frame after the victim.
  always_ff @(posedge clk) begin
    if (rst) begin
      hand <= '0;
    end else if (cmd.hand_adv) begin
      hand <= ptr_step;
    end
  end

  // First pass wants a clean unused frame, second pass a dirty one.
  assign vs_hit = occ[ptr] && !used[ptr] && (dirty[ptr] == pass);

  // Frame status bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= '0;
      used  <= '0;
      dirty <= '0;
    end else begin
      if (cmd.vs_scan && occ[ptr] && !vs_hit) begin
        used[ptr] <= 1'b0;
      end
      if (cmd.commit) begin
        case (op)
          OP_ASSIGN: begin
            occ[ptr]   <= 1'b1;
            used[ptr]  <= 1'b1;
            dirty[ptr] <= 1'b0;
          end
          OP_RELEASE: begin
            occ[ptr]   <= 1'b0;
            used[ptr]  <= 1'b0;
            dirty[ptr] <= 1'b0;
          end
          OP_TOUCH: begin
            if (occ[ptr]) begin
              used[ptr] <= 1'b1;
              if (wr) begin
                dirty[ptr] <= 1'b1;
              end
            end
          end
          default: begin
            occ[ptr] <= occ[ptr];
          end
        endcase
      end
    end
  end

  // Owner and page memory, one write and one registered read.
  always_ff @(posedge clk) begin
    if (cmd.commit && (op == OP_ASSIGN)) begin
      owner_mem[ptr] <= key;
      page_mem[ptr]  <= page;
    end
    if (cmd.mem_rd) begin
      rd_owner <= owner_mem[ptr];
      rd_page  <= page_mem[ptr];
    end
  end

  // Output register; a new result may load in the cycle the old one transfers.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report || cmd.report_zero) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_found       <= ((op == OP_TOUCH) || (op == OP_VICTIM)) ? occ[ptr] : 1'b1;
      out_frame       <= ptr;
      out_frame_dirty <= occ[ptr] & dirty[ptr];
      out_frame_owner <= occ[ptr] ? rd_owner : '0;
      out_frame_page  <= occ[ptr] ? rd_page : '0;
    end else if (cmd.report_zero) begin
      out_found       <= 1'b0;
      out_frame       <= '0;
      out_frame_dirty <= 1'b0;
      out_frame_owner <= '0;
      out_frame_page  <= '0;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts          = '0;
    sts.op       = op;
    sts.idx_ok   = (idx <= last_frame);
    sts.occ_ptr  = occ[ptr];
    sts.lk_match = occ[ptr] && (rd_owner == key) && (rd_page == page);
    sts.vs_hit   = vs_hit;
    sts.last     = (cnt == last_frame);
    sts.pass     = pass;
    sts.out_free = out_free;
  end

endmodule

`default_nettype wire

// ----- tb/tb_frame_table_clock_replacement.sv -----
`timescale 1ns / 1ps

module tb_frame_table_clock_replacement;
  import ftc_pkg::*;

  localparam int KEY_W  = KEY_BITS_DEF;
  localparam int PAGE_W = PAGE_BITS_DEF;

  // Codes outside the operation set; the block must answer them with an empty result.
  localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;

  localparam int SETTING_COUNT  = 9;
  localparam int BURST_ITEMS    = 136;
  localparam int STEADY_SETTING = 6;
  localparam int REPORT_CAP     = 200;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [KEY_W-1:0]      owner_key;
    logic [PAGE_W-1:0]     page_number;
    logic [FRAME_BITS-1:0] frame_index;
    logic                  write_flag;
  } frame_request_t;

  typedef struct packed {
    logic                  found;
    logic [FRAME_BITS-1:0] frame;
    logic                  frame_dirty;
    logic [KEY_W-1:0]      frame_owner;
    logic [PAGE_W-1:0]     frame_page;
  } frame_result_t;

  // Mirror of the frame table: predicts each result and checks what comes back.
  class frame_table_tracker;
    bit                 occ [FRAMES];
    bit                 used [FRAMES];
    bit                 dirty [FRAMES];
    logic [KEY_W-1:0]   owner [FRAMES];
    logic [PAGE_W-1:0]  page [FRAMES];
    int unsigned        hand;
    logic [CFG_BITS-1:0] frames_cfg;
    frame_result_t      awaited [$];
    int                 errors;
    int                 reports;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        occ[i]   = 1'b0;
        used[i]  = 1'b0;
        dirty[i] = 1'b0;
        owner[i] = '0;
        page[i]  = '0;
      end
      hand       = 0;
      frames_cfg = CFG_RESET;
      errors     = 0;
      reports    = 0;
    endfunction

    function void set_frames(logic [CFG_BITS-1:0] value);
      frames_cfg = value;
    endfunction

    // A zero count acts as one frame, a count above the table as the whole table.
    function int unsigned frame_count();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > FRAMES) return FRAMES;
      return frames_cfg;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Old contents of a frame; a free frame reports zeros.
    function frame_result_t describe(int unsigned f, bit hit);
      frame_result_t r;
      r = '0;
      r.found = hit;
      r.frame = FRAME_BITS'(f);
      if (occ[f]) begin
        r.frame_dirty = dirty[f];
        r.frame_owner = owner[f];
        r.frame_page  = page[f];
      end
      return r;
    endfunction

    // Clock-M: clean and unused first, then dirty and unused, clearing use bits on the way.
    function int unsigned choose_victim(int unsigned n);
      int unsigned start;
      int unsigned f;
      start = (hand < n) ? hand : 0;
      for (int pass = 0; pass < 2; pass++) begin
        for (int unsigned i = 0; i < n; i++) begin
          f = (start + i) % n;
          if (!occ[f]) continue;
          if (!used[f] && (dirty[f] == (pass == 1))) begin
            hand = (f + 1) % n;
            return f;
          end
          used[f] = 1'b0;
        end
      end
      hand = (start + 1) % n;
      return start;
    endfunction

    function void accept_request(frame_request_t rq);
      frame_result_t r;
      int unsigned   n;
      int unsigned   v;
      bit            hit;
      n   = frame_count();
      r   = '0;
      hit = 1'b0;
      case (rq.op)
        OP_LOOKUP: begin
          for (int unsigned i = 0; i < n && !hit; i++) begin
            if (occ[i] && owner[i] == rq.owner_key && page[i] == rq.page_number) begin
              r   = describe(i, 1'b1);
              hit = 1'b1;
            end
          end
        end
        OP_FIND_FREE: begin
          for (int unsigned i = 0; i < n && !hit; i++) begin
            if (!occ[i]) begin
              r   = describe(i, 1'b1);
              hit = 1'b1;
            end
          end
        end
        OP_ASSIGN: begin
          if (rq.frame_index < n) begin
            r = describe(rq.frame_index, 1'b1);
            occ[rq.frame_index]   = 1'b1;
            used[rq.frame_index]  = 1'b1;
            dirty[rq.frame_index] = 1'b0;
            owner[rq.frame_index] = rq.owner_key;
            page[rq.frame_index]  = rq.page_number;
          end
        end
        OP_RELEASE: begin
          if (rq.frame_index < n) begin
            r = describe(rq.frame_index, 1'b1);
            occ[rq.frame_index]   = 1'b0;
            used[rq.frame_index]  = 1'b0;
            dirty[rq.frame_index] = 1'b0;
          end
        end
        OP_VICTIM: begin
          v = choose_victim(n);
          r = describe(v, occ[v]);
        end
        OP_TOUCH: begin
          if (rq.frame_index < n && occ[rq.frame_index]) begin
            r = describe(rq.frame_index, 1'b1);
            used[rq.frame_index] = 1'b1;
            if (rq.write_flag) dirty[rq.frame_index] = 1'b1;
          end else if (rq.frame_index < n) begin
            r.frame = rq.frame_index;
          end
        end
        default: begin
        end
      endcase
      awaited.push_back(r);
    endfunction

    function string show(frame_result_t r);
      return $sformatf("found=%0b frame=%0d dirty=%0b owner=%h page=%h",
                       r.found, r.frame, r.frame_dirty, r.frame_owner, r.frame_page);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (reports < REPORT_CAP) begin
          $display("%0t: result with nothing awaited: %s", $time, show(got));
          reports++;
        end
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found || got.frame !== want.frame ||
          got.frame_dirty !== want.frame_dirty || got.frame_owner !== want.frame_owner ||
          got.frame_page !== want.frame_page) begin
        errors++;
        if (reports < REPORT_CAP) begin
          $display("%0t: result mismatch: expected %s, got %s", $time, show(want), show(got));
          reports++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_wr_en;
  logic [CFG_BITS-1:0] cfg_wr_data;
  bit                  no_idle = 1'b0;
  frame_table_tracker  tracker;

  ftc_req_if req_bus ();
  ftc_rsp_if rsp_bus ();

  frame_table_clock_replacement u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Present one request, idling first at random, and hold it until the transfer.
  task automatic send_request(input frame_request_t rq);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.op          <= rq.op;
    req_bus.owner_key   <= rq.owner_key;
    req_bus.page_number <= rq.page_number;
    req_bus.frame_index <= rq.frame_index;
    req_bus.write_flag  <= rq.write_flag;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    tracker.accept_request(rq);
  endtask

  task automatic send_fields(input logic [OP_BITS-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [PAGE_W-1:0] pg, input logic [FRAME_BITS-1:0] idx,
                             input logic wr);
    frame_request_t rq;
    rq.op          = op;
    rq.owner_key   = key;
    rq.page_number = pg;
    rq.frame_index = idx;
    rq.write_flag  = wr;
    send_request(rq);
  endtask

  // Change the frame count once every result has come back.
  task automatic set_frame_count(input logic [CFG_BITS-1:0] value);
    req_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_frames(value);
  endtask

  // Random request; small key and page pools and copies of stored pairs make lookups hit.
  function automatic frame_request_t random_request();
    frame_request_t rq;
    int unsigned    n;
    int unsigned    pick;
    int unsigned    f;
    n    = tracker.frame_count();
    pick = $urandom_range(0, 99);
    if (pick < 25) rq.op = OP_LOOKUP;
    else if (pick < 35) rq.op = OP_FIND_FREE;
    else if (pick < 55) rq.op = OP_ASSIGN;
    else if (pick < 65) rq.op = OP_RELEASE;
    else if (pick < 80) rq.op = OP_VICTIM;
    else if (pick < 95) rq.op = OP_TOUCH;
    else rq.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    rq.owner_key   = ($urandom_range(0, 1) != 0) ? KEY_W'($urandom_range(0, 3)) :
                                                   KEY_W'($urandom);
    rq.page_number = ($urandom_range(0, 1) != 0) ? PAGE_W'($urandom_range(0, 3)) :
                                                   PAGE_W'($urandom);
    rq.frame_index = ($urandom_range(0, 9) == 0) ? FRAME_BITS'($urandom_range(0, FRAMES - 1)) :
                                                   FRAME_BITS'($urandom_range(0, n - 1));
    rq.write_flag  = 1'($urandom_range(0, 1));
    if (rq.op == OP_LOOKUP && $urandom_range(0, 2) != 0) begin
      f = $urandom_range(0, n - 1);
      if (tracker.occ[f]) begin
        rq.owner_key   = tracker.owner[f];
        rq.page_number = tracker.page[f];
      end
    end
    return rq;
  endfunction

  // Result side: random back-pressure, check on every transfer.
  initial begin
    frame_result_t got;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        got.found       = rsp_bus.found;
        got.frame       = rsp_bus.frame;
        got.frame_dirty = rsp_bus.frame_dirty;
        got.frame_owner = rsp_bus.frame_owner;
        got.frame_page  = rsp_bus.frame_page;
        tracker.check_result(got);
      end
      rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 33);
    end
  end

  // Main sequence: reset, directed requests, then random bursts over several frame counts.
  initial begin
    logic [CFG_BITS-1:0] settings [SETTING_COUNT];
    tracker = new();
    settings = '{7'd8, 7'd1, 7'd0, 7'd127, 7'd2, 7'd33, 7'd64, 7'd5, 7'd100};
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.op          <= OP_LOOKUP;
    req_bus.owner_key   <= '0;
    req_bus.page_number <= '0;
    req_bus.frame_index <= '0;
    req_bus.write_flag  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: lookup miss, first free frame, victim falls back to the hand,
    // touch and release of a free frame.
    send_fields(OP_LOOKUP, 16'h0000, 16'h0000, 6'd0, 1'b0);
    send_fields(OP_FIND_FREE, 16'hffff, 16'hffff, 6'd63, 1'b1);
    send_fields(OP_VICTIM, 16'h0000, 16'h0000, 6'd0, 1'b0);
    send_fields(OP_TOUCH, 16'h0000, 16'h0000, 6'd5, 1'b1);
    send_fields(OP_RELEASE, 16'h0000, 16'h0000, 6'd63, 1'b0);
    // Fill a few frames with extreme keys, including a duplicate owner and page pair.
    send_fields(OP_ASSIGN, 16'hffff, 16'h0000, 6'd0, 1'b0);
    send_fields(OP_ASSIGN, 16'h0000, 16'hffff, 6'd63, 1'b1);
    send_fields(OP_ASSIGN, 16'hffff, 16'h0000, 6'd1, 1'b0);
    send_fields(OP_LOOKUP, 16'hffff, 16'h0000, 6'd0, 1'b0);
    send_fields(OP_LOOKUP, 16'h0000, 16'hffff, 6'd0, 1'b0);
    send_fields(OP_TOUCH, 16'h0000, 16'h0000, 6'd63, 1'b1);
    send_fields(OP_TOUCH, 16'h0000, 16'h0000, 6'd1, 1'b0);
    send_fields(OP_FIND_FREE, 16'h0000, 16'h0000, 6'd0, 1'b0);
    // Victim passes over used frames, then reaches clean and dirty ones.
    send_fields(OP_VICTIM, 16'h0000, 16'h0000, 6'd0, 1'b0);
    send_fields(OP_VICTIM, 16'h0000, 16'h0000, 6'd0, 1'b0);
    send_fields(OP_VICTIM, 16'h0000, 16'h0000, 6'd0, 1'b0);
    // Overwrite an occupied frame, then release and miss.
    send_fields(OP_ASSIGN, 16'h1234, 16'h4321, 6'd0, 1'b0);
    send_fields(OP_RELEASE, 16'h0000, 16'h0000, 6'd1, 1'b0);
    send_fields(OP_LOOKUP, 16'habcd, 16'h5555, 6'd0, 1'b0);
    send_fields(OP_SPARE_LO, 16'hffff, 16'hffff, 6'd63, 1'b1);
    send_fields(OP_SPARE_HI, 16'haaaa, 16'h5555, 6'd42, 1'b0);
    send_fields(OP_TOUCH, 16'h0000, 16'h0000, 6'd0, 1'b1);
    send_fields(OP_VICTIM, 16'h0000, 16'h0000, 6'd0, 1'b0);
    send_fields(OP_RELEASE, 16'h0000, 16'h0000, 6'd0, 1'b0);

    // Random bursts; one burst runs with no idling on either side.
    for (int k = 0; k < SETTING_COUNT; k++) begin
      set_frame_count(settings[k]);
      no_idle = (k == STEADY_SETTING);
      for (int j = 0; j < BURST_ITEMS; j++) send_request(random_request());
      no_idle = 1'b0;
    end

    req_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * FRAMES + 8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_frame_table_clock_replacement passed");
    end else begin
      $display("tb_frame_table_clock_replacement failed");
    end
    $finish;
  end

  // Watchdog, 8 ms.
  initial begin
    #8_000_000;
    $display("tb_frame_table_clock_replacement failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ftc_pkg.sv
src/ftc_req_if.sv
src/ftc_rsp_if.sv
src/ftc_ctrl.sv
src/ftc_dp.sv
src/frame_table_clock_replacement.sv
tb/tb_frame_table_clock_replacement.sv
